### sv/aro_pkg.sv
`timescale 1ns / 1ps

package aro_pkg;

  // Default table depth.
  localparam int MaxRangesDef = 16;

  // Guest to physical translation constants.
  localparam logic [31:0] AddrMask   = 32'h1FFF_FFFF;
  localparam logic [31:0] HighWindow = 32'hE000_0000;
  localparam logic [31:0] HighOffset = 32'h0000_1000;

  // Request kinds.
  typedef enum logic [1:0] {
    ModeNote      = 2'd0,
    ModeQuery     = 2'd1,
    ModeWriteback = 2'd2,
    ModeUnused    = 2'd3
  } aro_mode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan;
    logic apply;
    logic load;
  } aro_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } aro_status_t;

endpackage

### sv/aro_ctrl.sv
`timescale 1ns / 1ps

module aro_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  aro_pkg::aro_status_t status_i,
  output aro_pkg::aro_cmd_t    cmd_o
);
  import aro_pkg::*;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScan  = 4'b0010,
    StApply = 4'b0100,
    StLoad  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // A new request is taken only when the previous one has been handed over.
  assign in_ready_o = (state_q == StIdle);

  // Next state and command decode.
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = StApply;
        end
      end
      StApply: begin
        cmd_o.apply = 1'b1;
        state_d     = StLoad;
      end
      StLoad: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### sv/aro_dp.sv
`timescale 1ns / 1ps

module aro_dp #(
  parameter int MaxRanges = aro_pkg::MaxRangesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  aro_pkg::aro_cmd_t    cmd_i,
  output aro_pkg::aro_status_t status_o,
  input  logic [1:0]           mode_i,
  input  logic [31:0]          base_addr_i,
  input  logic [31:0]          length_i,
  input  logic                 claimed_flag_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 owned_o,
  output logic [4:0]           range_count_o,
  output logic [63:0]          overflow_count_o,
  output logic [63:0]          considered_count_o,
  output logic [63:0]          suppressed_count_o
);
  import aro_pkg::*;

  localparam int IdxW = (MaxRanges > 1) ? $clog2(MaxRanges) : 1;
  localparam int CntW = $clog2(MaxRanges + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxRanges);

  // Latched request.
  aro_mode_e   mode_q;
  logic [31:0] base_q;
  logic [31:0] len_q;
  logic        claimed_q;
  logic [31:0] key_q;

  // Table and scan state.
  logic [63:0]     mem_q [MaxRanges];
  logic [63:0]     rdata_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] scan_q;
  logic            pv_q;
  logic            hit_q;
  logic            owned_q;

  // Counters.
  logic [63:0] overflow_q;
  logic [63:0] considered_q;
  logic [63:0] suppressed_q;

  // Output register.
  logic        out_valid_q;
  logic        out_owned_q;
  logic [4:0]  out_count_q;
  logic [63:0] out_overflow_q;
  logic [63:0] out_considered_q;
  logic [63:0] out_suppressed_q;

  logic [31:0] key_d;
  logic        rd_en;
  logic [31:0] r_lo;
  logic [31:0] r_size;
  logic [32:0] r_hi;
  logic [32:0] q_hi;
  logic        match;
  logic        note_ok;
  logic        full;

  // Translate a guest address for queries; notes use the base as given.
  always_comb begin
    key_d = base_addr_i;
    if (aro_mode_e'(mode_i) == ModeQuery) begin
      key_d = base_addr_i & AddrMask;
      if (base_addr_i >= HighWindow) begin
        key_d = key_d + HighOffset;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q    <= aro_mode_e'(mode_i);
      base_q    <= base_addr_i;
      len_q     <= length_i;
      claimed_q <= claimed_flag_i;
      key_q     <= key_d;
    end
  end

  // Compare the entry read in the previous cycle against the request.
  assign r_lo   = rdata_q[63:32];
  assign r_size = rdata_q[31:0];
  assign r_hi   = {1'b0, r_lo} + {1'b0, r_size};
  assign q_hi   = {1'b0, key_q} + {1'b0, len_q};

  always_comb begin
    if (mode_q == ModeNote) begin
      match = (r_lo == key_q) && (r_size == len_q);
    end else begin
      match = (key_q >= r_lo) && (q_hi <= r_hi);
    end
  end

  assign rd_en   = cmd_i.scan && (scan_q < count_q);
  assign full    = (count_q >= CntMax);
  assign note_ok = (mode_q == ModeNote) && (len_q != 32'd0) && !hit_q;

  assign status_o.scan_done = !(scan_q < count_q) && !pv_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Table storage: one write port at the fill point, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && note_ok && !full) begin
      mem_q[count_q[IdxW-1:0]] <= {base_q, len_q};
    end
    if (rd_en) begin
      rdata_q <= mem_q[scan_q[IdxW-1:0]];
    end
  end

  // Scan walk, hit flag, entry count and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      scan_q       <= '0;
      pv_q         <= 1'b0;
      hit_q        <= 1'b0;
      owned_q      <= 1'b0;
      overflow_q   <= '0;
      considered_q <= '0;
      suppressed_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        scan_q <= '0;
        pv_q   <= 1'b0;
        hit_q  <= 1'b0;
      end else if (cmd_i.scan) begin
        pv_q <= rd_en;
        if (rd_en) begin
          scan_q <= scan_q + CntW'(1);
        end
        if (pv_q && match) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.apply) begin
        owned_q <= (mode_q == ModeQuery) && (len_q != 32'd0) && hit_q;
        if (note_ok) begin
          if (full) begin
            overflow_q <= overflow_q + 64'd1;
          end else begin
            count_q <= count_q + CntW'(1);
          end
        end
        if (mode_q == ModeWriteback) begin
          considered_q <= considered_q + 64'd1;
          if (claimed_q) begin
            suppressed_q <= suppressed_q + 64'd1;
          end
        end
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_owned_q      <= owned_q;
      out_count_q      <= 5'(count_q);
      out_overflow_q   <= overflow_q;
      out_considered_q <= considered_q;
      out_suppressed_q <= suppressed_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign owned_o            = out_owned_q;
  assign range_count_o      = out_count_q;
  assign overflow_count_o   = out_overflow_q;
  assign considered_count_o = out_considered_q;
  assign suppressed_count_o = out_suppressed_q;

  // The table never holds more entries than it has room for.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntMax)
    else $error("entry count exceeds table depth");

  // The scan pointer never runs past the filled part of the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni) scan_q <= count_q)
    else $error("scan pointer beyond entry count");

  // A result is only loaded when the output slot is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  // A writeback request bumps the considered counter by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply && (mode_q == ModeWriteback) |=>
      considered_q == $past(considered_q) + 64'd1)
    else $error("considered counter not advanced");

  // The table only grows by one entry, through an accepted note.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.apply |=> count_q == $past(count_q))
    else $error("entry count changed outside apply");

endmodule

### sv/address_range_ownership_table.sv
`timescale 1ns / 1ps

// Table of up to MaxRanges claimed physical address ranges with three 64-bit
// wrapping counters. Each request (note a written range, query ownership of a
// guest range, or count a writeback decision) returns one result carrying the
// owned flag, the number of held ranges and the counters after the request is
// applied. Requests are handled one at a time: a request walks the filled part
// of the table through a single registered read port, one entry per cycle, and
// then moves its result into the output register once that is free. The next
// request is accepted once the previous result has been moved into the output
// register, even while that result still waits.
// Table entries need no clearing after reset; only filled entries are read.
module address_range_ownership_table #(
  parameter int MaxRanges = aro_pkg::MaxRangesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] base_addr_i,
  input  logic [31:0] length_i,
  input  logic        claimed_flag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        owned_o,
  output logic [4:0]  range_count_o,
  output logic [63:0] overflow_count_o,
  output logic [63:0] considered_count_o,
  output logic [63:0] suppressed_count_o
);
  import aro_pkg::*;

  aro_cmd_t    cmd;
  aro_status_t status;

  // Request sequencing.
  aro_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Table, counters and output register.
  aro_dp #(
    .MaxRanges (MaxRanges)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .mode_i             (mode_i),
    .base_addr_i        (base_addr_i),
    .length_i           (length_i),
    .claimed_flag_i     (claimed_flag_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .owned_o            (owned_o),
    .range_count_o      (range_count_o),
    .overflow_count_o   (overflow_count_o),
    .considered_count_o (considered_count_o),
    .suppressed_count_o (suppressed_count_o)
  );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import aro_pkg::*;

  localparam int          TableDepth = MaxRangesDef;
  localparam int unsigned CycleLimit = 500000;
  localparam int          DrainWait  = 60;

  // Translation constants for guest addresses.
  localparam logic [31:0] GuestMask   = 32'h1FFF_FFFF;
  localparam logic [31:0] GuestHigh   = 32'hE000_0000;
  localparam logic [31:0] GuestOffset = 32'h0000_1000;

  // One status result as the block reports it.
  typedef struct {
    logic        owned;
    logic [4:0]  range_count;
    logic [63:0] overflow_count;
    logic [63:0] considered_count;
    logic [63:0] suppressed_count;
  } table_status_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  mode_i;
  logic [31:0] base_addr_i;
  logic [31:0] length_i;
  logic        claimed_flag_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        owned_o;
  logic [4:0]  range_count_o;
  logic [63:0] overflow_count_o;
  logic [63:0] considered_count_o;
  logic [63:0] suppressed_count_o;

  // Shadow copy of the ownership table and its counters.
  logic [31:0] claim_base [TableDepth];
  logic [31:0] claim_size [TableDepth];
  int          claim_count;
  logic [63:0] notes_dropped;
  logic [63:0] wb_seen;
  logic [63:0] wb_suppressed;

  table_status_t expected_status_q[$];
  int            mismatches;
  int unsigned   cycle_count;
  bit            src_idle;
  bit            sink_idle;
  int            sink_hold_cycles;

  address_range_ownership_table DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .mode_i             (mode_i),
    .base_addr_i        (base_addr_i),
    .length_i           (length_i),
    .claimed_flag_i     (claimed_flag_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .owned_o            (owned_o),
    .range_count_o      (range_count_o),
    .overflow_count_o   (overflow_count_o),
    .considered_count_o (considered_count_o),
    .suppressed_count_o (suppressed_count_o)
  );

  always #4 clk_i = ~clk_i;

  // Apply one request to the shadow table and return the status it yields.
  function automatic table_status_t apply_request(input logic [1:0] mode,
                                                  input logic [31:0] base,
                                                  input logic [31:0] len,
                                                  input logic claimed);
    table_status_t st;
    logic          held;
    logic [31:0]   phys;
    logic [32:0]   q_lo;
    logic [32:0]   q_hi;
    logic [32:0]   r_hi;
    st.owned = 1'b0;
    case (aro_mode_e'(mode))
      ModeNote: begin
        if (len != 32'd0) begin
          held = 1'b0;
          for (int k = 0; k < claim_count; k++) begin
            if (claim_base[k] == base && claim_size[k] == len) held = 1'b1;
          end
          if (!held) begin
            if (claim_count >= TableDepth) begin
              notes_dropped = notes_dropped + 64'd1;
            end else begin
              claim_base[claim_count] = base;
              claim_size[claim_count] = len;
              claim_count++;
            end
          end
        end
      end
      ModeQuery: begin
        if (len != 32'd0) begin
          phys = (base & GuestMask) + ((base >= GuestHigh) ? GuestOffset : 32'd0);
          q_lo = {1'b0, phys};
          q_hi = q_lo + {1'b0, len};
          for (int k = 0; k < claim_count; k++) begin
            r_hi = {1'b0, claim_base[k]} + {1'b0, claim_size[k]};
            if (q_lo >= {1'b0, claim_base[k]} && q_hi <= r_hi) st.owned = 1'b1;
          end
        end
      end
      ModeWriteback: begin
        wb_seen = wb_seen + 64'd1;
        if (claimed) wb_suppressed = wb_suppressed + 64'd1;
      end
      default: ;
    endcase
    st.range_count      = 5'(claim_count);
    st.overflow_count   = notes_dropped;
    st.considered_count = wb_seen;
    st.suppressed_count = wb_suppressed;
    return st;
  endfunction

  // Offer one request, hold it until accepted, then record its expected status.
  task automatic send_request(input logic [1:0] mode, input logic [31:0] base,
                              input logic [31:0] len, input logic claimed);
    int gap;
    gap = src_idle ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= mode;
    base_addr_i    <= base;
    length_i       <= len;
    claimed_flag_i <= claimed;
    do @(posedge clk_i); while (!in_ready_o);
    expected_status_q.push_back(apply_request(mode, base, len, claimed));
  endtask

  // Draw one random request. Queries mostly aim at held ranges and their edges.
  task automatic random_request(input int note_pct);
    int          pick;
    int          k;
    logic [1:0]  mode;
    logic [31:0] base;
    logic [31:0] len;
    logic [32:0] phys;
    pick = $urandom_range(0, 99);
    base = $urandom;
    len  = $urandom;
    if (pick < note_pct) begin
      mode = ModeNote;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        len = 32'd0;
      end else if (pick < 40 && claim_count > 0) begin
        k    = $urandom_range(0, claim_count - 1);
        base = claim_base[k];
        len  = claim_size[k];
      end else begin
        if ($urandom_range(0, 9) < 7) base = $urandom_range(0, 32'h2000_0FFF);
        pick = $urandom_range(0, 99);
        if (pick < 60) len = $urandom_range(1, 32'h4000);
        else if (pick < 85) len = $urandom_range(1, 32'h0100_0000);
      end
    end else if (pick < note_pct + 45) begin
      mode = ModeQuery;
      if (claim_count > 0 && $urandom_range(0, 99) < 65) begin
        k    = $urandom_range(0, claim_count - 1);
        len  = $urandom_range(1, claim_size[k]);
        phys = {1'b0, claim_base[k]} + 33'($urandom_range(0, claim_size[k] - len));
        // Nudge the window just past either edge now and then.
        case ($urandom_range(0, 3))
          0:       phys = phys - 33'd1;
          1:       len  = len + 32'd1;
          default: ;
        endcase
        // Map the physical start back to a guest address, low or high window.
        if (phys < 33'h0000_1000 || (phys < 33'h2000_0000 && $urandom_range(0, 1))) begin
          base = {3'($urandom_range(0, 6)), phys[28:0]};
        end else if (phys < 33'h2000_1000) begin
          phys = phys - 33'h0000_1000;
          base = {3'b111, phys[28:0]};
        end else begin
          base = phys[31:0];
        end
      end else if ($urandom_range(0, 1)) begin
        len = $urandom_range(0, 32'h1000);
      end
      if ($urandom_range(0, 99) < 4) len = 32'd0;
    end else if (pick < 97) begin
      mode = ModeWriteback;
    end else begin
      mode = ModeUnused;
    end
    send_request(mode, base, len, 1'($urandom));
  endtask

  // Empty table: nothing is owned.
  task automatic test_empty_table();
    send_request(ModeQuery, 32'h0000_1000, 32'h10, 1'b0);
    send_request(ModeQuery, 32'h0000_1000, 32'h0, 1'b1);
  endtask

  // Zero length, duplicate and distinct notes, including the widest range.
  task automatic test_note_rules();
    send_request(ModeNote, 32'h0000_1000, 32'h0, 1'b0);
    send_request(ModeNote, 32'h0000_1000, 32'h100, 1'b0);
    send_request(ModeNote, 32'h0000_1000, 32'h100, 1'b1);
    send_request(ModeNote, 32'h0000_1000, 32'h200, 1'b0);
    send_request(ModeNote, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_request(ModeNote, 32'h0000_0000, 32'h1, 1'b0);
  endtask

  // Containment at the range edges, and the full-width query.
  task automatic test_query_bounds();
    send_request(ModeQuery, 32'h0000_1000, 32'h100, 1'b0);
    send_request(ModeQuery, 32'h0000_11FF, 32'h1, 1'b0);
    send_request(ModeQuery, 32'h0000_0FFF, 32'h2, 1'b0);
    send_request(ModeQuery, 32'h0000_1100, 32'h101, 1'b0);
    send_request(ModeQuery, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
  endtask

  // Guest addresses in the high window gain the fixed offset.
  task automatic test_translation();
    send_request(ModeNote, 32'h0000_2000, 32'h1000, 1'b0);
    send_request(ModeQuery, 32'hE000_1000, 32'h1000, 1'b0);
    send_request(ModeQuery, 32'hA000_2000, 32'h10, 1'b0);
    send_request(ModeQuery, 32'hE000_0FFF, 32'h2, 1'b0);
  endtask

  // Writeback decisions, plain and suppressed.
  task automatic test_writeback();
    send_request(ModeWriteback, 32'h0, 32'h0, 1'b0);
    send_request(ModeWriteback, 32'h0, 32'h0, 1'b1);
    send_request(ModeWriteback, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
  endtask

  // The unused mode only reports status.
  task automatic test_unused_mode();
    send_request(ModeUnused, 32'h0000_1000, 32'h100, 1'b1);
    send_request(ModeUnused, 32'hFFFF_FFFF, 32'h0, 1'b0);
  endtask

  // Note-heavy traffic that fills the table and then overflows it.
  task automatic test_table_fill();
    repeat (150) random_request(50);
  endtask

  // Main random mix with idle cycles on both sides.
  task automatic test_random_mix();
    repeat (1200) random_request(25);
  endtask

  // Back-to-back traffic with no idle cycles at all.
  task automatic test_back_to_back();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    repeat (400) random_request(25);
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  // Results stay blocked for a long stretch while requests keep coming.
  task automatic test_output_stall();
    src_idle         = 1'b0;
    sink_hold_cycles = 400;
    repeat (100) random_request(25);
    src_idle         = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // Compare every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    table_status_t exp_st;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_status_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual owned %0h count %0h",
                 $time, owned_o, range_count_o);
        mismatches++;
      end else begin
        exp_st = expected_status_q.pop_front();
        check_field("owned", 64'(exp_st.owned), 64'(owned_o));
        check_field("range_count", 64'(exp_st.range_count), 64'(range_count_o));
        check_field("overflow_count", exp_st.overflow_count, overflow_count_o);
        check_field("considered_count", exp_st.considered_count, considered_count_o);
        check_field("suppressed_count", exp_st.suppressed_count, suppressed_count_o);
      end
    end
  end

  // Result side: random stalls per result, plus long hold-offs on request.
  initial begin : result_sink
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (sink_hold_cycles) @(negedge clk_i);
        sink_hold_cycles = 0;
      end
      stall = sink_idle ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("address_range_ownership_table regression: fail");
      $finish;
    end
  end

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    mode_i           = ModeNote;
    base_addr_i      = 32'd0;
    length_i         = 32'd0;
    claimed_flag_i   = 1'b0;
    claim_count      = 0;
    notes_dropped    = 64'd0;
    wb_seen          = 64'd0;
    wb_suppressed    = 64'd0;
    mismatches       = 0;
    cycle_count      = 0;
    src_idle         = 1'b1;
    sink_idle        = 1'b1;
    sink_hold_cycles = 0;
    for (int k = 0; k < TableDepth; k++) begin
      claim_base[k] = 32'd0;
      claim_size[k] = 32'd0;
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_note_rules();
    test_query_bounds();
    test_translation();
    test_writeback();
    test_unused_mode();
    test_table_fill();
    test_random_mix();
    test_back_to_back();
    test_output_stall();

    // Drain the outstanding results, then wait on so that any stray result is caught.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("address_range_ownership_table regression: pass");
    end else begin
      $display("address_range_ownership_table regression: fail");
    end
    $finish;
  end

endmodule
